FILE: design/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_TRAVERSE   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_TRAV = 2'b10
    } t_state;

endpackage

FILE: design/bdq_ram.sv
module bdq_ram #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    parameter int WIDTH = bdq_pkg::VALUE_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bounded_deque_with_traverse_unit.sv
// channel | direction | handshake                | payload
// request | in        | i_in_valid / o_in_ready  | i_in  (operation, value)
// result  | out       | o_out_valid / i_out_ready| o_out (item_value, status, last)
//
// Push and pop each give one result from the output register.
// Traverse streams one stored value per cycle, while the result side accepts, through the
// registered memory read port.
// A stall on the result side holds the pending read data and pauses the stream.
// Synchronous active-low reset empties the queue; stored values stay undefined.
module bounded_deque_with_traverse_unit #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bdq_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bdq_pkg::t_out o_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    bdq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_front, n_front;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_issued, n_issued;
    logic [AW-1:0]   r_trav_addr, n_trav_addr;
    logic            r_pend, n_pend;
    logic            r_out_valid, n_out_valid;
    bdq_pkg::t_out   r_out, n_out;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [bdq_pkg::VALUE_W-1:0] rd_data;

    logic          in_fire;
    logic          out_free;
    logic          full;
    logic          empty;
    logic [AW-1:0] front_p1;
    logic [AW-1:0] front_m1;
    logic [AW-1:0] back_addr;
    logic [AW-1:0] trav_p1;
    logic [AW:0]   front_inc;
    logic [AW:0]   trav_inc;
    logic [CW:0]   back_sum;
    logic          trav_last;

    bdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (bdq_pkg::VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_in.value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == bdq_pkg::S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign full       = (r_count == CW'(DEPTH));
    assign empty      = (r_count == '0);
    assign trav_last  = (r_issued == r_count);

    assign front_inc = (AW+1)'(r_front) + (AW+1)'(1);
    assign front_p1  = (front_inc == (AW+1)'(DEPTH)) ? '0 : front_inc[AW-1:0];
    assign front_m1  = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign trav_inc  = (AW+1)'(r_trav_addr) + (AW+1)'(1);
    assign trav_p1   = (trav_inc == (AW+1)'(DEPTH)) ? '0 : trav_inc[AW-1:0];
    assign back_sum  = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign back_addr = (back_sum >= (CW+1)'(DEPTH)) ?
                       AW'(back_sum - (CW+1)'(DEPTH)) : back_sum[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_issued    = r_issued;
        n_trav_addr = r_trav_addr;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr_en       = 1'b0;
        wr_addr     = back_addr;
        rd_en       = 1'b0;
        rd_addr     = r_trav_addr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            bdq_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_in.operation)
                        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_out       = '{item_value: '0, status: bdq_pkg::ST_OK, last: 1'b1};
                            if (full) begin
                                n_out.status = bdq_pkg::ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in.operation == bdq_pkg::OP_PUSH_FRONT) begin
                                    wr_addr = front_m1;
                                    n_front = front_m1;
                                end
                            end
                        end
                        bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                            n_out_valid = 1'b1;
                            n_out       = '{item_value: '0, status: bdq_pkg::ST_OK, last: 1'b1};
                            if (empty) begin
                                n_out.status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (i_in.operation == bdq_pkg::OP_POP_FRONT) begin
                                    n_front = front_p1;
                                end
                            end
                        end
                        bdq_pkg::OP_TRAVERSE: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_out       = '{item_value: '0, status: bdq_pkg::ST_EMPTY,
                                                last: 1'b1};
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = r_front;
                                n_trav_addr = front_p1;
                                n_issued    = CW'(1);
                                n_pend      = 1'b1;
                                n_state     = bdq_pkg::S_TRAV;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bdq_pkg::S_TRAV: begin
                if (r_pend && out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{item_value: rd_data, status: bdq_pkg::ST_OK,
                                    last: trav_last};
                    n_pend      = 1'b0;
                    if (trav_last) begin
                        n_state = bdq_pkg::S_IDLE;
                    end
                end
                // advance the read while the pending word is free to move and entries remain
                if ((!r_pend || out_free) && !trav_last) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_trav_addr;
                    n_trav_addr = trav_p1;
                    n_issued    = r_issued + CW'(1);
                    n_pend      = 1'b1;
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_issued    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_issued    <= n_issued;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_trav_addr <= n_trav_addr;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: verif/bounded_deque_with_traverse_unit_tb.sv
module bounded_deque_with_traverse_unit_tb;

    localparam int RING_DEPTH      = bdq_pkg::DEPTH_DEF;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 60;
    localparam int SETTLE_CYCLES   = 20;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [bdq_pkg::OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          in_valid  = 1'b0;
    logic          out_ready = 1'b0;
    bdq_pkg::t_in  in_req    = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    bdq_pkg::t_out o_out;

    bdq_pkg::t_in  pending_reqs[$];
    bdq_pkg::t_out due_results[$];

    logic signed [bdq_pkg::VALUE_W-1:0] ring_vals [0:RING_DEPTH-1];
    int ring_front = 0;
    int ring_count = 0;

    logic req_taken      = 1'b0;
    int   reqs_taken     = 0;
    int   idle_cycles    = 0;
    int   mismatch_count = 0;

    int   burst_left = 0;
    int   gap_left   = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;
    int   mode_left  = 0;
    int   stall_mode = 0;

    always #6 i_clk = ~i_clk;

    bounded_deque_with_traverse_unit #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (in_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out      (o_out)
    );

    function automatic void due_push(logic signed [bdq_pkg::VALUE_W-1:0] v,
                                     logic [bdq_pkg::STATUS_W-1:0] st, logic lst);
        bdq_pkg::t_out r;
        r.item_value = v;
        r.status     = st;
        r.last       = lst;
        due_results.push_back(r);
    endfunction

    function automatic void deque_apply(bdq_pkg::t_in req);
        int i;
        case (req.operation)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                if (ring_count >= RING_DEPTH) begin
                    due_push('0, bdq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (req.operation == bdq_pkg::OP_PUSH_FRONT) begin
                        ring_front = (ring_front + RING_DEPTH - 1) % RING_DEPTH;
                        ring_vals[ring_front] = req.value;
                    end else begin
                        ring_vals[(ring_front + ring_count) % RING_DEPTH] = req.value;
                    end
                    ring_count++;
                    due_push('0, bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
                if (ring_count == 0) begin
                    due_push('0, bdq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    if (req.operation == bdq_pkg::OP_POP_FRONT)
                        ring_front = (ring_front + 1) % RING_DEPTH;
                    ring_count--;
                    due_push('0, bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::OP_TRAVERSE: begin
                if (ring_count == 0) begin
                    due_push('0, bdq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (i = 0; i < ring_count; i++)
                        due_push(ring_vals[(ring_front + i) % RING_DEPTH], bdq_pkg::ST_OK,
                                 i == ring_count - 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void note_fault(string what, bdq_pkg::t_out want, bdq_pkg::t_out got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%s: expected value %0d status %0d last %0d, got value %0d status %0d last %0d",
                     what, want.item_value, want.status, want.last,
                     got.item_value, got.status, got.last);
    endfunction

    function automatic void check_result(bdq_pkg::t_out got);
        bdq_pkg::t_out want;
        if (due_results.size() == 0) begin
            note_fault("unexpected result", '0, got);
        end else begin
            want = due_results.pop_front();
            if (got.item_value !== want.item_value || got.status !== want.status ||
                got.last !== want.last)
                note_fault("wrong result", want, got);
        end
    endfunction

    function automatic void queue_req(logic [bdq_pkg::OP_W-1:0] op,
                                      logic signed [bdq_pkg::VALUE_W-1:0] v);
        bdq_pkg::t_in r;
        r.operation = op;
        r.value     = v;
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [bdq_pkg::OP_W-1:0] pick_op(int push_w, int pop_w, int trav_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_w)
            return $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_BACK : bdq_pkg::OP_PUSH_FRONT;
        if (r < push_w + pop_w)
            return $urandom_range(0, 1) ? bdq_pkg::OP_POP_BACK : bdq_pkg::OP_POP_FRONT;
        if (r < push_w + pop_w + trav_w)
            return bdq_pkg::OP_TRAVERSE;
        return bdq_pkg::OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    always @(posedge i_clk) begin : watch_channels
        logic moved;
        logic taken_now;
        moved     = 1'b0;
        taken_now = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && out_ready) begin
                moved = 1'b1;
                check_result(o_out);
            end
            if (in_valid && o_in_ready) begin
                moved     = 1'b1;
                taken_now = 1'b1;
                reqs_taken++;
                deque_apply(in_req);
            end
        end
        req_taken <= taken_now;
        if (moved || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("bounded_deque_with_traverse_unit: mismatch");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin : drive_req
        logic         next_valid;
        bdq_pkg::t_in next_req;
        next_valid = in_valid;
        next_req   = in_req;
        if (in_valid && req_taken)
            next_valid = 1'b0;
        if (i_rst_n && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                next_req   = pending_reqs.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= next_valid;
        in_req   <= next_req;
    end

    always @(negedge i_clk) begin : drive_ready
        logic next_ready;
        if (!hold_done && reqs_taken >= HOLD_OFF_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ($urandom_range(0, 3) != 0);
                default: next_ready = ($urandom_range(0, 1) == 1);
            endcase
        end
        out_ready <= next_ready;
    end

    initial begin : run_stimulus
        int i;
        queue_req(bdq_pkg::OP_POP_FRONT, $urandom);
        queue_req(bdq_pkg::OP_POP_BACK, $urandom);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);
        queue_req(OP_UNUSED_LO, $urandom);
        queue_req(OP_UNUSED_MID, $urandom);
        queue_req(OP_UNUSED_HI, $urandom);
        queue_req(bdq_pkg::OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        queue_req(bdq_pkg::OP_PUSH_BACK, 32'sh8000_0000);
        queue_req(bdq_pkg::OP_PUSH_FRONT, -32'sd1);
        queue_req(bdq_pkg::OP_PUSH_BACK, 32'sd0);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);
        queue_req(bdq_pkg::OP_PUSH_FRONT, 32'sd1);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);
        queue_req(bdq_pkg::OP_POP_FRONT, $urandom);
        queue_req(bdq_pkg::OP_POP_BACK, $urandom);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);
        queue_req(bdq_pkg::OP_POP_BACK, $urandom);
        queue_req(bdq_pkg::OP_POP_FRONT, $urandom);
        queue_req(bdq_pkg::OP_POP_FRONT, $urandom);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);

        // fill past full, then drain past empty
        for (i = 0; i < 74; i++)
            queue_req(pick_op(96, 1, 2), $urandom);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);
        for (i = 0; i < 74; i++)
            queue_req(pick_op(2, 94, 3), $urandom);
        queue_req(bdq_pkg::OP_TRAVERSE, $urandom);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || in_valid)
            @(posedge i_clk);
        while (due_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        while (due_results.size() > 0)
            note_fault("missing result", due_results.pop_front(), '0);
        if (mismatch_count == 0)
            $display("bounded_deque_with_traverse_unit: match");
        else
            $display("bounded_deque_with_traverse_unit: mismatch");
        $finish;
    end

endmodule

FILE: bounded_deque_with_traverse_unit.f
design/bdq_pkg.sv
design/bdq_ram.sv
design/bounded_deque_with_traverse_unit.sv
verif/bounded_deque_with_traverse_unit_tb.sv
